// File: src/gamepad_report_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Gamepad report decoder assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_DECODER_UNIT_DEFINES_SVH
`define GAMEPAD_REPORT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define GPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gpr assertion failed");
// antecedent implies consequent in the same cycle
`define GPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gpr implication failed");
`else
`define GPR_ASSERT(lbl, clk, rstn, prop)
`define GPR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/gpr_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder package
// Item types, report constants and button remap helpers.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam logic [7:0] ID_FMT_A     = 8'h01;
  localparam logic [7:0] ID_FMT_B     = 8'h11;
  localparam logic [3:0] LEN_FMT_A    = 4'd11;
  localparam logic [3:0] LEN_FMT_B    = 4'd13;
  localparam logic [3:0] COUNT_MAX    = 4'hF;
  localparam int         CAP_DEPTH    = 11;
  localparam logic [7:0] STICK_CENTRE = 8'd128;
  localparam int         NUM_AXES     = 6;
  localparam int         RAW_BTNS     = 14;
  localparam int         MASK_W       = 18;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_FMT_A   = 2'd1,
    KIND_FMT_B   = 2'd2,
    KIND_DISC    = 2'd3
  } report_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        left_x;
    logic [7:0]        left_y;
    logic [7:0]        right_x;
    logic [7:0]        right_y;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic [MASK_W-1:0] button_mask;
    logic [1:0]        report_kind;
  } out_item_t;

  // axes order: lx, ly, rx, ry, ltrig, rtrig
  typedef struct packed {
    report_kind_e                  kind;
    logic [NUM_AXES-1:0][7:0]      axes;
    logic [MASK_W-1:0]             buttons;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [4:0] BTN_DEST [RAW_BTNS] = '{
    5'd1, 5'd0, 5'd2, 5'd3, 5'd8, 5'd9, 5'd12,
    5'd13, 5'd15, 5'd14, 5'd10, 5'd11, 5'd16, 5'd17
  };

  // up = bit 4, right = 5, down = 6, left = 7; 8 and above is neutral
  localparam logic [7:0] HAT_DIRS [16] = '{
    8'h10, 8'h30, 8'h20, 8'h60, 8'h40, 8'hC0, 8'h80, 8'h90,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [MASK_W-1:0] remap(input logic [RAW_BTNS-1:0] raw,
                                              input logic [3:0] hat);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < RAW_BTNS; i++) begin
      m[BTN_DEST[i]] = m[BTN_DEST[i]] | raw[i];
    end
    m[7:0] = m[7:0] | HAT_DIRS[hat];
    return m;
  endfunction

endpackage

// File: src/gpr_stream_if.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface gpr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/gpr_front.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder front end
// Captures report bytes, counts length and classifies finished reports.
// ----------------------------------------------------------------------------
module gpr_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  gpr_stream_if.sink   in_i,
  input  logic         q_full_i,
  output logic         cmd_push_o,
  output gpr_pkg::cmd_t cmd_o
);

  logic [3:0] count_q, count_d, count_inc;
  logic [7:0] ident_q, ident_d, ident_v;
  logic [7:0] cap_q [gpr_pkg::CAP_DEPTH];
  logic [7:0] cv    [gpr_pkg::CAP_DEPTH];
  logic       act, last, accept;
  logic [7:0] b;
  logic [gpr_pkg::RAW_BTNS-1:0] raw_a, raw_b;

  assign act  = in_i.data.action;
  assign last = in_i.data.last_byte;
  assign b    = in_i.data.data_byte;

  // plain bytes never push, so they pass while the queue is full
  assign in_i.ready = !q_full_i || (!act && !last);
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_push_o = accept && (act || last);

  always_comb begin
    count_inc = (count_q < gpr_pkg::COUNT_MAX) ? count_q + 4'd1 : count_q;
    ident_v   = (count_q == 4'd0) ? b : ident_q;
    for (int i = 0; i < gpr_pkg::CAP_DEPTH; i++) begin
      cv[i] = (count_q == 4'(i + 1)) ? b : cap_q[i];
    end
    raw_a = {cv[7][5:0], cv[6]};
    // format B face buttons: 0x20, 0x40, 0x80, 0x10
    raw_b = {cv[8][1:0], cv[7], cv[6][4], cv[6][7], cv[6][6], cv[6][5]};
  end

  always_comb begin
    cmd_o.kind    = gpr_pkg::KIND_IGNORED;
    cmd_o.axes    = '0;
    cmd_o.buttons = '0;
    if (act) begin
      cmd_o.kind = gpr_pkg::KIND_DISC;
    end else if (ident_v == gpr_pkg::ID_FMT_A && count_inc >= gpr_pkg::LEN_FMT_A) begin
      cmd_o.kind    = gpr_pkg::KIND_FMT_A;
      cmd_o.axes[0] = cv[0];
      cmd_o.axes[1] = cv[1];
      cmd_o.axes[2] = cv[2];
      cmd_o.axes[3] = cv[3];
      cmd_o.axes[4] = cv[4];
      cmd_o.axes[5] = cv[5];
      cmd_o.buttons = gpr_pkg::remap(raw_a, cv[8][3:0]);
    end else if (ident_v == gpr_pkg::ID_FMT_B && count_inc >= gpr_pkg::LEN_FMT_B) begin
      cmd_o.kind    = gpr_pkg::KIND_FMT_B;
      cmd_o.axes[0] = cv[1];
      cmd_o.axes[1] = cv[2];
      cmd_o.axes[2] = cv[3];
      cmd_o.axes[3] = cv[4];
      cmd_o.axes[4] = cv[9];
      cmd_o.axes[5] = cv[10];
      cmd_o.buttons = gpr_pkg::remap(raw_b, cv[6][3:0]);
    end
  end

  always_comb begin
    count_d = count_q;
    ident_d = ident_q;
    if (accept) begin
      if (act || last) begin
        count_d = 4'd0;
      end else begin
        count_d = count_inc;
      end
      if (!act && count_q == 4'd0) begin
        ident_d = b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      ident_q <= 8'd0;
    end else begin
      count_q <= count_d;
      ident_q <= ident_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !act) begin
      for (int i = 0; i < gpr_pkg::CAP_DEPTH; i++) begin
        if (count_q == 4'(i + 1)) begin
          cap_q[i] <= b;
        end
      end
    end
  end

endmodule

// File: src/gpr_queue.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder command queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module gpr_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gpr_pkg::cmd_t       data_i,
  input  logic                pop_i,
  output gpr_pkg::cmd_t       data_o,
  output gpr_pkg::q_status_t  status_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gpr_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign status_o.full  = (cnt_q == CW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: src/gpr_back.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder back end
// Applies commands to held controller state and drives the result register.
// ----------------------------------------------------------------------------
module gpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpr_pkg::cmd_t      cmd_i,
  input  gpr_pkg::q_status_t q_status_i,
  output logic               pop_o,
  gpr_stream_if.source       out_o
);

  logic [gpr_pkg::NUM_AXES-1:0][7:0] axes_q, axes_d;
  logic [gpr_pkg::MASK_W-1:0]        btn_q, btn_d;
  logic                              valid_q;
  gpr_pkg::out_item_t                res_q, res_d;

  assign pop_o       = !q_status_i.empty && (!valid_q || out_o.ready);
  assign out_o.valid = valid_q;
  assign out_o.data  = res_q;

  always_comb begin
    axes_d = axes_q;
    btn_d  = btn_q;
    unique case (cmd_i.kind)
      gpr_pkg::KIND_FMT_A, gpr_pkg::KIND_FMT_B: begin
        axes_d = cmd_i.axes;
        btn_d  = cmd_i.buttons;
      end
      gpr_pkg::KIND_DISC: begin
        axes_d = {8'd0, 8'd0, gpr_pkg::STICK_CENTRE, gpr_pkg::STICK_CENTRE,
                  gpr_pkg::STICK_CENTRE, gpr_pkg::STICK_CENTRE};
        btn_d  = '0;
      end
      default: begin
      end
    endcase
    res_d.left_x        = axes_d[0];
    res_d.left_y        = axes_d[1];
    res_d.right_x       = axes_d[2];
    res_d.right_y       = axes_d[3];
    res_d.left_trigger  = axes_d[4];
    res_d.right_trigger = axes_d[5];
    res_d.button_mask   = btn_d;
    res_d.report_kind   = cmd_i.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axes_q  <= {8'd0, 8'd0, gpr_pkg::STICK_CENTRE, gpr_pkg::STICK_CENTRE,
                  gpr_pkg::STICK_CENTRE, gpr_pkg::STICK_CENTRE};
      btn_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        axes_q  <= axes_d;
        btn_q   <= btn_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: src/gamepad_report_decoder_unit.sv
// ----------------------------------------------------------------------------
// Gamepad report decoder
// Byte-wise controller input report decoder with held stick/button state.
// ----------------------------------------------------------------------------
// in_i carries one report byte (or a disconnect event) per transfer; the byte
// marked last_byte closes the report. out_o carries one result per closed
// report or disconnect, holding the stick, trigger and button state after
// the update and the report kind.
// Throughput: one input transfer per cycle, sustained while out_o is ready.
// The last byte or disconnect event writes a queue entry at its transfer;
// the back end pops that entry into the result register once the register
// is empty or being taken, and out_o is valid from that register.
// Up to QUEUE_DEPTH results plus the output register are buffered. When the
// receiver stalls and the queue fills, last bytes and disconnect events are
// held off; bytes inside a report are still taken.
// Reset drops any report in progress, empties the queue, and sets the sticks
// to 128, the triggers and buttons to 0.
// ----------------------------------------------------------------------------
`include "gamepad_report_decoder_unit_defines.svh"

module gamepad_report_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gpr_stream_if.sink   in_i,
  gpr_stream_if.source out_o
);

  logic               cmd_push;
  logic               q_pop;
  gpr_pkg::cmd_t      cmd_in, cmd_out;
  gpr_pkg::q_status_t q_status;

  gpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_full_i   (q_status.full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  gpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .data_i   (cmd_in),
    .pop_i    (q_pop),
    .data_o   (cmd_out),
    .status_o (q_status)
  );

  gpr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .q_status_i (q_status),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

  `GPR_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, cmd_push, !q_status.full)
  `GPR_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, !in_i.ready, q_status.full)
  `GPR_ASSERT_IMP(a_disc_neutral, clk_i, rst_ni,
    out_o.valid && out_o.data.report_kind == gpr_pkg::KIND_DISC,
    out_o.data.left_x == gpr_pkg::STICK_CENTRE &&
    out_o.data.right_y == gpr_pkg::STICK_CENTRE &&
    out_o.data.left_trigger == 8'd0 && out_o.data.button_mask == '0)
  `GPR_ASSERT(a_result_from_queue, clk_i, rst_ni,
    $rose(out_o.valid) |-> $past(!q_status.empty))

endmodule
